>>> design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion, also checked through reset
`define ASSERT_ON(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/dntc_pkg.sv
// Shared constants, types and elaboration helpers for the decimal-to-text-cells block.
package dntc_pkg;

  localparam int DIGIT_COUNT_DEF = 8;
  localparam int ROW_STRIDE_DEF  = 128;

  localparam int GLYPH_W = 6;

  localparam logic [GLYPH_W-1:0] GLYPH_MINUS   = 6'd14;
  localparam logic [GLYPH_W-1:0] GLYPH_ZERO    = 6'd17;
  localparam logic [GLYPH_W-1:0] GLYPH_NINE    = 6'd26;
  localparam logic [GLYPH_W-1:0] GLYPH_UNKNOWN = 6'd63;

  localparam int MINUS_COLUMN  = 2;
  localparam int MINUS_ROW     = 13;
  localparam int COLUMN_OFFSET = 12;

  // Per-item side information carried alongside the digit pipeline
  typedef struct packed {
    logic        neg;       // value was negative: minus cell goes first
    logic [31:0] row_cell;  // cell index of digit position 0 (wraps)
  } dntc_meta_t;

  // 10^n, evaluated at elaboration
  function automatic logic [63:0] pow10(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) p = p * 64'd10;
    return p;
  endfunction

  // Quotient bits needed for the top position of a 32-bit magnitude
  function automatic int top_bits(input int digits);
    logic [63:0] d;
    int          b;
    d = pow10(digits - 1);
    b = 0;
    while ((d << b) <= 64'hFFFF_FFFF) b++;
    return b;
  endfunction

  // Quotient bits resolved for digit position p
  function automatic int pos_bits(input int p, input int digits);
    return (p == 0) ? top_bits(digits) : 4;
  endfunction

  // Width of the quotient accumulator carried through the steps
  function automatic int quot_width(input int digits);
    return (top_bits(digits) > 4) ? top_bits(digits) : 4;
  endfunction

  // Index of the first subtract step of digit position p
  function automatic int step_base(input int p, input int digits);
    return (p == 0) ? 0 : top_bits(digits) + 4 * (p - 1);
  endfunction

  // Total subtract steps in the pipeline
  function automatic int step_count(input int digits);
    return top_bits(digits) + 4 * (digits - 1);
  endfunction

endpackage

>>> design/dntc_front.sv
// Input stage: captures an item, forms the magnitude and the row cell index.
module dntc_front #(
  parameter int ROW_STRIDE = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [31:0]  in_value,
  input  logic [6:0]          in_column,
  input  logic [5:0]          in_row,
  output logic                valid_o,
  output logic [31:0]         mag_o,
  output dntc_pkg::dntc_meta_t meta_o
);
  import dntc_pkg::*;

  logic        valid_r;
  logic [31:0] mag_r;
  dntc_meta_t  meta_r;

  logic [31:0] raw;
  logic [31:0] mag_nxt;
  logic [31:0] row_base;
  dntc_meta_t  meta_nxt;

  // Magnitude as unsigned, so the most negative value still works
  assign raw      = in_value;
  assign mag_nxt  = raw[31] ? (32'd0 - raw) : raw;
  assign row_base = 32'(ROW_STRIDE) * {26'd0, in_row};

  always_comb begin
    meta_nxt.neg      = raw[31];
    meta_nxt.row_cell = {25'd0, in_column} + row_base - 32'(COLUMN_OFFSET);
  end

  // Stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      mag_r  <= mag_nxt;
      meta_r <= meta_nxt;
    end
  end

  assign valid_o = valid_r;
  assign mag_o   = mag_r;
  assign meta_o  = meta_r;

endmodule

>>> design/dntc_step.sv
// One restoring-division step: conditional subtract of a shifted power of ten.
module dntc_step #(
  parameter int DIGIT_COUNT = 8,
  parameter int QW          = 9,
  parameter int POS         = 0,
  parameter int BIT         = 0,
  parameter bit FIRST       = 1'b0,
  parameter bit LAST        = 1'b0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        valid_i,
  input  logic [31:0]                 mag_i,
  input  logic [QW-1:0]               q_i,
  input  logic [DIGIT_COUNT*6-1:0]    glyph_i,
  input  logic [DIGIT_COUNT-1:0]      nz_i,
  input  dntc_pkg::dntc_meta_t        meta_i,
  output logic                        valid_o,
  output logic [31:0]                 mag_o,
  output logic [QW-1:0]               q_o,
  output logic [DIGIT_COUNT*6-1:0]    glyph_o,
  output logic [DIGIT_COUNT-1:0]      nz_o,
  output dntc_pkg::dntc_meta_t        meta_o
);
  import dntc_pkg::*;

  localparam logic [63:0] SUB = pow10(DIGIT_COUNT - 1 - POS) << BIT;

  logic                       valid_r;
  logic [31:0]                mag_r;
  logic [QW-1:0]              q_r;
  logic [DIGIT_COUNT*6-1:0]   glyph_r;
  logic [DIGIT_COUNT-1:0]     nz_r;
  dntc_meta_t                 meta_r;

  logic                       take;
  logic [QW-1:0]              q_base;
  logic [31:0]                mag_nxt;
  logic [QW-1:0]              q_nxt;
  logic [DIGIT_COUNT*6-1:0]   glyph_nxt;
  logic [DIGIT_COUNT-1:0]     nz_nxt;

  // Compare, subtract, set one quotient bit; the last bit of a position fixes its glyph
  always_comb begin
    q_base    = FIRST ? '0 : q_i;
    take      = ({32'd0, mag_i} >= SUB);
    mag_nxt   = take ? (mag_i - SUB[31:0]) : mag_i;
    q_nxt     = q_base;
    q_nxt[BIT] = take;
    glyph_nxt = glyph_i;
    nz_nxt    = nz_i;
    if (LAST) begin
      nz_nxt[POS] = (q_nxt != '0);
      if (q_nxt <= QW'(9)) begin
        glyph_nxt[POS*GLYPH_W +: GLYPH_W] = GLYPH_ZERO + {2'b00, q_nxt[3:0]};
      end else begin
        glyph_nxt[POS*GLYPH_W +: GLYPH_W] = GLYPH_UNKNOWN;
      end
    end
  end

  // Stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (en && valid_i) begin
      mag_r   <= mag_nxt;
      q_r     <= q_nxt;
      glyph_r <= glyph_nxt;
      nz_r    <= nz_nxt;
      meta_r  <= meta_i;
    end
  end

  assign valid_o = valid_r;
  assign mag_o   = mag_r;
  assign q_o     = q_r;
  assign glyph_o = glyph_r;
  assign nz_o    = nz_r;
  assign meta_o  = meta_r;

endmodule

>>> design/dntc_emit.sv
// Output sequencer: turns one finished number into its cell writes, one per cycle while out_stall is low.
module dntc_emit #(
  parameter int DIGIT_COUNT = 8,
  parameter int ROW_STRIDE  = 128
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pipe_valid,
  input  logic [DIGIT_COUNT*6-1:0]    glyph_i,
  input  logic [DIGIT_COUNT-1:0]      nz_i,
  input  dntc_pkg::dntc_meta_t        meta_i,
  input  logic [31:0]                 base,
  input  logic                        out_stall,
  output logic                        take,
  output logic                        out_valid,
  output logic [31:0]                 out_cell_address,
  output logic [5:0]                  out_glyph,
  output logic                        out_last
);
  import dntc_pkg::*;

  localparam int PW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam logic [PW-1:0] LAST_POS = PW'(DIGIT_COUNT - 1);
  localparam logic [31:0] MINUS_CELL = 32'(MINUS_COLUMN + ROW_STRIDE * MINUS_ROW);

  // Item being written out
  logic                 busy_r;
  logic                 minus_r;
  logic [PW-1:0]        pos_r;
  logic [GLYPH_W-1:0]   glyph_r [DIGIT_COUNT];
  logic [31:0]          row_cell_r;

  // Output register
  logic                 out_valid_r;
  logic [31:0]          out_addr_r;
  logic [GLYPH_W-1:0]   out_glyph_r;
  logic                 out_last_r;

  logic                 slot_free;
  logic                 fire;
  logic                 fire_last;
  logic [PW-1:0]        first_pos;
  logic [31:0]          cell_sel;
  logic [31:0]          addr_nxt;
  logic [GLYPH_W-1:0]   glyph_nxt;
  logic                 last_nxt;

  // Handshake: send a write when the output register is free, load a new number when idle or on the final write
  always_comb begin
    slot_free = !out_valid_r || !out_stall;
    fire      = busy_r && slot_free;
    fire_last = fire && !minus_r && (pos_r == LAST_POS);
    take      = pipe_valid && (!busy_r || fire_last);
  end

  // First non-zero position; the last one is always written
  always_comb begin
    first_pos = LAST_POS;
    for (int p = DIGIT_COUNT - 1; p >= 0; p--) begin
      if (nz_i[p]) first_pos = PW'(p);
    end
  end

  // Next write
  always_comb begin
    cell_sel  = minus_r ? MINUS_CELL : (row_cell_r + 32'(pos_r));
    addr_nxt  = base + {cell_sel[29:0], 2'b00};
    glyph_nxt = minus_r ? GLYPH_MINUS : glyph_r[pos_r];
    last_nxt  = !minus_r && (pos_r == LAST_POS);
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      minus_r <= 1'b0;
      pos_r   <= '0;
    end else if (take) begin
      busy_r  <= 1'b1;
      minus_r <= meta_i.neg;
      pos_r   <= first_pos;
    end else if (fire) begin
      if (minus_r) begin
        minus_r <= 1'b0;
      end else if (pos_r == LAST_POS) begin
        busy_r <= 1'b0;
      end else begin
        pos_r <= pos_r + PW'(1);
      end
    end
  end

  // Item payload
  always_ff @(posedge clk) begin
    if (take) begin
      row_cell_r <= meta_i.row_cell;
      for (int p = 0; p < DIGIT_COUNT; p++) begin
        glyph_r[p] <= glyph_i[p*GLYPH_W +: GLYPH_W];
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= fire;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_addr_r  <= addr_nxt;
      out_glyph_r <= glyph_nxt;
      out_last_r  <= last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cell_address = out_addr_r;
  assign out_glyph        = out_glyph_r;
  assign out_last         = out_last_r;

endmodule

>>> design/decimal_number_to_text_cells.sv
// Top level: signed number to a burst of character-cell writes.
//
// Input channel (in_valid/in_stall): value, column, row of one number. A
// transfer happens on a clock edge with in_valid high and in_stall low.
// Output channel (out_valid/out_stall): one cell write per transfer, byte
// address and glyph, with out_last on the final write of a number. A
// negative number gives the minus cell first; leading zeros are skipped.
// cfg_write_en/cfg_write_data load the text memory base address; write it
// only while no number is in flight.
// Each number gives one cell write per cycle while out_stall is low (1 to
// DIGIT_COUNT+1 writes, at most 9 by default): the single output port sets the
// rate. The input is taken every cycle while the pipeline has room.
// The digits come from a chain of conditional-subtract stages, one quotient
// bit each (37 for eight digits); the first write reaches out_valid through
// the input stage, the step stages, the sequencer and the output register.
// Reset (rst_n low, synchronous) empties the pipeline, drops out_valid and
// clears the base address. out_stall holds the output register; numbers
// queue behind it in the sequencer and the pipeline, nothing is lost or
// repeated, and in_stall rises once the last stage holds a number that
// cannot move on.
module decimal_number_to_text_cells #(
  parameter int DIGIT_COUNT = dntc_pkg::DIGIT_COUNT_DEF,
  parameter int ROW_STRIDE  = dntc_pkg::ROW_STRIDE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_write_en,
  input  logic [31:0]        cfg_write_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_value,
  input  logic [6:0]         in_column,
  input  logic [5:0]         in_row,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_cell_address,
  output logic [5:0]         out_glyph,
  output logic               out_last
);
  import dntc_pkg::*;

  localparam int QW = quot_width(DIGIT_COUNT);
  localparam int NS = step_count(DIGIT_COUNT);

  logic [31:0] text_memory_base_r;
  logic        en;
  logic        take;

  // Pipeline stage signals; index 0 is the input stage
  logic                       st_valid [NS+1];
  logic [31:0]                st_mag   [NS+1];
  logic [QW-1:0]              st_q     [NS+1];
  logic [DIGIT_COUNT*6-1:0]   st_glyph [NS+1];
  logic [DIGIT_COUNT-1:0]     st_nz    [NS+1];
  dntc_meta_t                 st_meta  [NS+1];

  // Base address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_memory_base_r <= '0;
    end else if (cfg_write_en) begin
      text_memory_base_r <= cfg_write_data;
    end
  end

  // Whole pipeline moves unless its last stage holds an item the sequencer cannot take
  assign en       = !st_valid[NS] || take;
  assign in_stall = !en;

  dntc_front #(
    .ROW_STRIDE (ROW_STRIDE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_value  (in_value),
    .in_column (in_column),
    .in_row    (in_row),
    .valid_o   (st_valid[0]),
    .mag_o     (st_mag[0]),
    .meta_o    (st_meta[0])
  );

  assign st_q[0]     = '0;
  assign st_glyph[0] = '0;
  assign st_nz[0]    = '0;

  // Division chain: every digit position, every quotient bit, one stage each
  for (genvar p = 0; p < DIGIT_COUNT; p++) begin : g_pos
    for (genvar j = 0; j < pos_bits(p, DIGIT_COUNT); j++) begin : g_bit
      localparam int S = step_base(p, DIGIT_COUNT) + j;
      dntc_step #(
        .DIGIT_COUNT (DIGIT_COUNT),
        .QW          (QW),
        .POS         (p),
        .BIT         (pos_bits(p, DIGIT_COUNT) - 1 - j),
        .FIRST       (j == 0),
        .LAST        (j == pos_bits(p, DIGIT_COUNT) - 1)
      ) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .valid_i (st_valid[S]),
        .mag_i   (st_mag[S]),
        .q_i     (st_q[S]),
        .glyph_i (st_glyph[S]),
        .nz_i    (st_nz[S]),
        .meta_i  (st_meta[S]),
        .valid_o (st_valid[S+1]),
        .mag_o   (st_mag[S+1]),
        .q_o     (st_q[S+1]),
        .glyph_o (st_glyph[S+1]),
        .nz_o    (st_nz[S+1]),
        .meta_o  (st_meta[S+1])
      );
    end
  end

  dntc_emit #(
    .DIGIT_COUNT (DIGIT_COUNT),
    .ROW_STRIDE  (ROW_STRIDE)
  ) u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .pipe_valid       (st_valid[NS]),
    .glyph_i          (st_glyph[NS]),
    .nz_i             (st_nz[NS]),
    .meta_i           (st_meta[NS]),
    .base             (text_memory_base_r),
    .out_stall        (out_stall),
    .take             (take),
    .out_valid        (out_valid),
    .out_cell_address (out_cell_address),
    .out_glyph        (out_glyph),
    .out_last         (out_last)
  );

endmodule

>>> design/dntc_check.sv
// Port-level checker for the decimal-to-text-cells block, with its bind.
`include "assert_macros.svh"

module dntc_check (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_cell_address,
  input logic [5:0]  out_glyph,
  input logic        out_last
);
  import dntc_pkg::*;

  // Reset empties the output register
  `ASSERT_ON(a_reset_clears, clk, !rst_n |=> !out_valid, "output valid after reset")

  // A stalled write stays offered and unchanged
  `ASSERT_RST(a_hold_valid, clk, rst_n, out_valid && out_stall |=> out_valid, "write dropped under stall")
  `ASSERT_RST(a_hold_data, clk, rst_n, out_valid && out_stall |=> $stable(out_cell_address) && $stable(out_glyph) && $stable(out_last), "write changed under stall")

  // The minus cell always has digits after it
  `ASSERT_RST(a_minus_not_last, clk, rst_n, out_valid && (out_glyph == GLYPH_MINUS) |-> !out_last, "minus marked last")

  // Only known glyph codes go out
  `ASSERT_RST(a_glyph_known, clk, rst_n, out_valid |-> (out_glyph == GLYPH_MINUS) || (out_glyph == GLYPH_UNKNOWN) || ((out_glyph >= GLYPH_ZERO) && (out_glyph <= GLYPH_NINE)), "bad glyph code")

endmodule

bind decimal_number_to_text_cells dntc_check u_dntc_check (.*);
